/* hdl/mexp_pkg.sv */
// Package for the modular exponentiation core.
// Holds default widths, configuration register indexes and the controller state type.
// No dependencies.
package mexp_pkg;

    localparam int WORD_WIDTH_DEF = 32;
    localparam int EXP_BITS_DEF   = 32;

    // Configuration port register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'b1;

    localparam int MODULUS_RESET  = 2;
    localparam int EXPONENT_RESET = 0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_DONE
    } state_t;

endpackage

/* hdl/mexp_mulmod.sv */
// Bit-serial interleaved modular multiplier: result = (x * y) mod n.
// Takes one bit of x per cycle, most significant first; needs x, y < n except
// that x is used only as a bit source. Depends on mexp_pkg.
module mexp_mulmod #(
    parameter int WORD_WIDTH = mexp_pkg::WORD_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [WORD_WIDTH-1:0] x,
    input  logic [WORD_WIDTH-1:0] y,
    input  logic [WORD_WIDTH-1:0] n,
    output logic                  done,
    output logic [WORD_WIDTH-1:0] result
);

    localparam int CNT_W = (WORD_WIDTH > 1) ? $clog2(WORD_WIDTH) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_WIDTH - 1);

    logic [WORD_WIDTH-1:0] x_sh_reg, x_sh_next;
    logic [WORD_WIDTH-1:0] y_reg, y_next;
    logic [WORD_WIDTH-1:0] n_reg, n_next;
    logic [WORD_WIDTH-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [WORD_WIDTH+1:0] sum;
    logic [WORD_WIDTH+2:0] diff1;
    logic [WORD_WIDTH+2:0] diff2;
    logic [WORD_WIDTH-1:0] step;

    // One step: acc = (2*acc + bit*y) mod n. The sum stays below 3n, so
    // subtracting 2n if that leaves it non-negative, else n if that does, finishes it.
    always_comb
    begin
        sum   = {1'b0, acc_reg, 1'b0}
              + (x_sh_reg[WORD_WIDTH-1] ? {2'b00, y_reg} : {(WORD_WIDTH + 2){1'b0}});
        diff1 = {1'b0, sum} - {3'b000, n_reg};
        diff2 = {1'b0, sum} - {2'b00, n_reg, 1'b0};
        if (!diff2[WORD_WIDTH+2])
        begin
            step = diff2[WORD_WIDTH-1:0];
        end
        else if (!diff1[WORD_WIDTH+2])
        begin
            step = diff1[WORD_WIDTH-1:0];
        end
        else
        begin
            step = sum[WORD_WIDTH-1:0];
        end
    end

    always_comb
    begin
        x_sh_next = x_sh_reg;
        y_next    = y_reg;
        n_next    = n_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_sh_next = x;
            y_next    = y;
            n_next    = n;
            acc_next  = '0;
            cnt_next  = CNT_LAST;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next  = step;
            x_sh_next = x_sh_reg << 1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_sh_reg <= x_sh_next;
        y_reg    <= y_next;
        n_reg    <= n_next;
        acc_reg  <= acc_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

/* hdl/modular_exponentiation_core.sv */
// Modular exponentiation core: power_mod = base^exponent mod modulus, left-to-right binary.
// A modulus below 2 gives 0 with no product. Every modular product runs in the single
// bit-serial multiplier, so the core works on one word at a time.
// The next word is taken while a finished result waits in the output register.
// Reset (async, active low) sets modulus to 2, exponent to 0 and empties the block.
module modular_exponentiation_core #(
    parameter int WORD_WIDTH = mexp_pkg::WORD_WIDTH_DEF,
    parameter int EXP_BITS   = mexp_pkg::EXP_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [((WORD_WIDTH > EXP_BITS) ? WORD_WIDTH : EXP_BITS)-1:0] cfg_data,
    input  logic [WORD_WIDTH-1:0]          base,
    input  logic                           base_valid,
    output logic                           base_stall,
    output logic [WORD_WIDTH-1:0]          power_mod,
    output logic                           result_valid,
    input  logic                           result_stall
);

    localparam int EC_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
    localparam logic [EC_W-1:0] EC_LAST = EC_W'(EXP_BITS - 1);
    localparam logic [WORD_WIDTH-1:0] WORD_ONE = WORD_WIDTH'(1);

    mexp_pkg::state_t state_reg, state_next;

    logic [WORD_WIDTH-1:0] modulus_reg, modulus_next;
    logic [EXP_BITS-1:0]   exponent_reg, exponent_next;
    logic [WORD_WIDTH-1:0] b_reg, b_next;
    logic [WORD_WIDTH-1:0] s_reg, s_next;
    logic [EXP_BITS-1:0]   e_sh_reg, e_sh_next;
    logic [EC_W-1:0]       ecnt_reg, ecnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic [WORD_WIDTH-1:0] out_data_reg, out_data_next;

    logic                  accept;
    logic                  modulus_small;
    logic                  out_free;
    logic                  mul_start;
    logic [WORD_WIDTH-1:0] op_x;
    logic [WORD_WIDTH-1:0] op_y;
    logic                  mul_done;
    logic [WORD_WIDTH-1:0] mul_result;

    assign base_stall    = (state_reg != mexp_pkg::ST_IDLE);
    assign accept        = base_valid && !base_stall;
    assign modulus_small = (modulus_reg[WORD_WIDTH-1:1] == '0);
    assign out_free      = !out_valid_reg || !result_stall;

    mexp_mulmod #(
        .WORD_WIDTH(WORD_WIDTH)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .x      (op_x),
        .y      (op_y),
        .n      (modulus_reg),
        .done   (mul_done),
        .result (mul_result)
    );

    always_comb
    begin
        modulus_next  = modulus_reg;
        exponent_next = exponent_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                mexp_pkg::CFG_MODULUS:  modulus_next  = cfg_data[WORD_WIDTH-1:0];
                mexp_pkg::CFG_EXPONENT: exponent_next = cfg_data[EXP_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = modulus_small ? mexp_pkg::ST_DONE : mexp_pkg::ST_REDUCE;
                end
            end
            mexp_pkg::ST_REDUCE:
            begin
                if (mul_done)
                begin
                    state_next = mexp_pkg::ST_SQUARE;
                end
            end
            mexp_pkg::ST_SQUARE:
            begin
                if (mul_done)
                begin
                    if (e_sh_reg[EXP_BITS-1])
                    begin
                        state_next = mexp_pkg::ST_MULT;
                    end
                    else if (ecnt_reg == '0)
                    begin
                        state_next = mexp_pkg::ST_DONE;
                    end
                end
            end
            mexp_pkg::ST_MULT:
            begin
                if (mul_done)
                begin
                    state_next = (ecnt_reg == '0) ? mexp_pkg::ST_DONE : mexp_pkg::ST_SQUARE;
                end
            end
            mexp_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = mexp_pkg::ST_IDLE;
                end
            end
            default: state_next = mexp_pkg::ST_IDLE;
        endcase
    end

    // Datapath and multiplier control. A new product is started in the same
    // cycle that the previous one finishes. Squares after the first take both
    // operands from the result; a multiply pairs it with the reduced base b.
    always_comb
    begin
        b_next         = b_reg;
        s_next         = s_reg;
        e_sh_next      = e_sh_reg;
        ecnt_next      = ecnt_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_data_next  = out_data_reg;
        mul_start      = 1'b0;
        op_x           = mul_result;
        op_y           = mul_result;
        unique case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (modulus_small)
                    begin
                        s_next = '0;
                    end
                    else
                    begin
                        // Reduce the base as base * 1 mod n.
                        mul_start = 1'b1;
                        op_x      = base;
                        op_y      = WORD_ONE;
                    end
                end
            end
            mexp_pkg::ST_REDUCE:
            begin
                if (mul_done)
                begin
                    b_next    = mul_result;
                    s_next    = WORD_ONE;
                    e_sh_next = exponent_reg;
                    ecnt_next = EC_LAST;
                    mul_start = 1'b1;
                    op_x      = WORD_ONE;
                    op_y      = WORD_ONE;
                end
            end
            mexp_pkg::ST_SQUARE:
            begin
                if (mul_done)
                begin
                    s_next = mul_result;
                    if (e_sh_reg[EXP_BITS-1])
                    begin
                        mul_start = 1'b1;
                        op_y      = b_reg;
                    end
                    else if (ecnt_reg != '0)
                    begin
                        mul_start = 1'b1;
                        e_sh_next = e_sh_reg << 1;
                        ecnt_next = ecnt_reg - 1'b1;
                    end
                end
            end
            mexp_pkg::ST_MULT:
            begin
                if (mul_done)
                begin
                    s_next = mul_result;
                    if (ecnt_reg != '0)
                    begin
                        mul_start = 1'b1;
                        e_sh_next = e_sh_reg << 1;
                        ecnt_next = ecnt_reg - 1'b1;
                    end
                end
            end
            mexp_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = s_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mexp_pkg::ST_IDLE;
            modulus_reg   <= WORD_WIDTH'(mexp_pkg::MODULUS_RESET);
            exponent_reg  <= EXP_BITS'(mexp_pkg::EXPONENT_RESET);
            ecnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            modulus_reg   <= modulus_next;
            exponent_reg  <= exponent_next;
            ecnt_reg      <= ecnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg        <= b_next;
        s_reg        <= s_next;
        e_sh_reg     <= e_sh_next;
        out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign power_mod    = out_data_reg;

endmodule

/* hdl/mexp_checker.sv */
// Port-level checker for the modular exponentiation core, with its bind statement.
// Depends on mexp_pkg and modular_exponentiation_core.
module mexp_checker #(
    parameter int WORD_WIDTH = mexp_pkg::WORD_WIDTH_DEF,
    parameter int EXP_BITS   = mexp_pkg::EXP_BITS_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_write,
    input logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [((WORD_WIDTH > EXP_BITS) ? WORD_WIDTH : EXP_BITS)-1:0] cfg_data,
    input logic [WORD_WIDTH-1:0]          base,
    input logic                           base_valid,
    input logic                           base_stall,
    input logic [WORD_WIDTH-1:0]          power_mod,
    input logic                           result_valid,
    input logic                           result_stall
);

    // A stalled result word stays.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result word dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(power_mod))
        else $error("result word changed while stalled");

    // Once a word is taken the block is busy with it on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        base_valid && !base_stall |=> base_stall)
        else $error("input not stalled after a word was taken");

    // A new result can only come out of a word that was in progress.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(base_stall))
        else $error("result appeared with no word in progress");

endmodule

bind modular_exponentiation_core mexp_checker #(
    .WORD_WIDTH(WORD_WIDTH),
    .EXP_BITS  (EXP_BITS)
) u_mexp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .base         (base),
    .base_valid   (base_valid),
    .base_stall   (base_stall),
    .power_mod    (power_mod),
    .result_valid (result_valid),
    .result_stall (result_stall)
);
